@@ src/sstp_pkg.sv @@
// Shared types and codes for the tunnel frame parser.
// Used by sstp_parse_core and sstp_frame_parser; no dependencies.
package sstp_pkg;

	// parse phases
	localparam logic [3:0] PH_VER  = 4'd0;
	localparam logic [3:0] PH_FLAG = 4'd1;
	localparam logic [3:0] PH_LHI  = 4'd2;
	localparam logic [3:0] PH_LLO  = 4'd3;
	localparam logic [3:0] PH_DATA = 4'd4;
	localparam logic [3:0] PH_MTH  = 4'd5;
	localparam logic [3:0] PH_MTL  = 4'd6;
	localparam logic [3:0] PH_CNH  = 4'd7;
	localparam logic [3:0] PH_CNL  = 4'd8;
	localparam logic [3:0] PH_ARSV = 4'd9;
	localparam logic [3:0] PH_AID  = 4'd10;
	localparam logic [3:0] PH_ALH  = 4'd11;
	localparam logic [3:0] PH_ALL  = 4'd12;
	localparam logic [3:0] PH_ADAT = 4'd13;
	localparam logic [3:0] PH_SKIP = 4'd14;

	// result kinds
	localparam logic [2:0] KIND_DATA       = 3'd0;
	localparam logic [2:0] KIND_CTRL_HDR   = 3'd1;
	localparam logic [2:0] KIND_ATTR_START = 3'd2;
	localparam logic [2:0] KIND_ATTR_BYTE  = 3'd3;
	localparam logic [2:0] KIND_FRAME_END  = 3'd4;
	localparam logic [2:0] KIND_ERROR      = 3'd5;

	// error codes
	localparam logic [2:0] ERR_NONE         = 3'd0;
	localparam logic [2:0] ERR_VERSION      = 3'd1;
	localparam logic [2:0] ERR_FRAME_LEN    = 3'd2;
	localparam logic [2:0] ERR_CTRL_BODY    = 3'd3;
	localparam logic [2:0] ERR_ATTR_LEN     = 3'd4;
	localparam logic [2:0] ERR_ATTR_OVERRUN = 3'd5;
	localparam logic [2:0] ERR_ATTR_MISSING = 3'd6;

	localparam logic [11:0] HDR_BYTES = 12'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  byte_value;
		logic [15:0] msg_type;
		logic [15:0] attribute_count;
		logic [7:0]  attr_ident;
		logic [11:0] attribute_length;
		logic        frame_done;
		logic [2:0]  error_code;
	} result_t;

endpackage

@@ src/sstp_parse_core.sv @@
// Per-byte frame parsing state and next-state logic.
// Depends on sstp_pkg; driven one registered byte at a time by sstp_frame_parser.
module sstp_parse_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       in_byte,
	input  logic [7:0]       expected_version,
	output logic             res_valid,
	output sstp_pkg::result_t res
);
	import sstp_pkg::*;

	logic [3:0]  phase_q, phase_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [11:0] left_q, left_d;
	logic        ctrl_q, ctrl_d;
	logic [15:0] mtype_q, mtype_d;
	logic [15:0] attrs_q, attrs_d;
	logic [7:0]  attr_id_q, attr_id_d;
	logic [11:0] attr_left_q, attr_left_d;
	logic        halted_q, halted_d;

	always_comb begin
		logic [11:0] left_dec;
		logic [11:0] total;
		logic [11:0] attr_dec;
		logic        do_fail;
		logic [2:0]  fail_code;
		logic        do_bnd;

		phase_d     = phase_q;
		len_hi_d    = len_hi_q;
		left_d      = left_q;
		ctrl_d      = ctrl_q;
		mtype_d     = mtype_q;
		attrs_d     = attrs_q;
		attr_id_d   = attr_id_q;
		attr_left_d = attr_left_q;
		halted_d    = halted_q;
		res         = '0;
		res_valid   = 1'b0;
		do_fail     = 1'b0;
		fail_code   = ERR_NONE;
		do_bnd      = 1'b0;
		left_dec    = left_q - 12'd1;
		total       = {len_hi_q[3:0], in_byte};
		attr_dec    = attr_left_q - 12'd1;

		if (!halted_q) begin
			case (phase_q)
				PH_VER: begin
					if (in_byte != expected_version) begin
						halted_d       = 1'b1;
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_VERSION;
					end else begin
						ctrl_d  = 1'b0;
						phase_d = PH_FLAG;
					end
				end
				PH_FLAG: begin
					ctrl_d  = in_byte[0];
					phase_d = PH_LHI;
				end
				PH_LHI: begin
					len_hi_d = in_byte;
					phase_d  = PH_LLO;
				end
				PH_LLO: begin
					if (total < HDR_BYTES) begin
						halted_d       = 1'b1;
						phase_d        = PH_VER;
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_FRAME_LEN;
					end else begin
						left_d = total - HDR_BYTES;
						if (!ctrl_q) begin
							if (left_d == '0) begin
								phase_d        = PH_VER;
								res_valid      = 1'b1;
								res.kind       = KIND_FRAME_END;
								res.frame_done = 1'b1;
							end else begin
								phase_d = PH_DATA;
							end
						end else if (left_d < HDR_BYTES) begin
							do_fail   = 1'b1;
							fail_code = ERR_CTRL_BODY;
						end else begin
							phase_d = PH_MTH;
						end
					end
				end
				PH_DATA: begin
					left_d         = left_dec;
					res_valid      = 1'b1;
					res.kind       = KIND_DATA;
					res.byte_value = in_byte;
					if (left_dec == '0) begin
						phase_d        = PH_VER;
						res.frame_done = 1'b1;
					end
				end
				PH_MTH: begin
					mtype_d = {in_byte, 8'h00};
					left_d  = left_dec;
					phase_d = PH_MTL;
				end
				PH_MTL: begin
					mtype_d = {mtype_q[15:8], in_byte};
					left_d  = left_dec;
					phase_d = PH_CNH;
				end
				PH_CNH: begin
					attrs_d = {in_byte, 8'h00};
					left_d  = left_dec;
					phase_d = PH_CNL;
				end
				PH_CNL: begin
					attrs_d             = {attrs_q[15:8], in_byte};
					left_d              = left_dec;
					res_valid           = 1'b1;
					res.kind            = KIND_CTRL_HDR;
					res.msg_type        = mtype_q;
					res.attribute_count = attrs_d;
					do_bnd              = 1'b1;
				end
				PH_ARSV, PH_AID, PH_ALH: begin
					if (phase_q == PH_AID)
						attr_id_d = in_byte;
					if (phase_q == PH_ALH)
						len_hi_d = in_byte;
					left_d = left_dec;
					if (left_dec == '0) begin
						do_fail   = 1'b1;
						fail_code = ERR_ATTR_OVERRUN;
					end else begin
						phase_d = phase_q + 4'd1;
					end
				end
				PH_ALL: begin
					left_d = left_dec;
					if (total < HDR_BYTES) begin
						do_fail   = 1'b1;
						fail_code = ERR_ATTR_LEN;
					end else if ((total - HDR_BYTES) > left_dec) begin
						do_fail   = 1'b1;
						fail_code = ERR_ATTR_OVERRUN;
					end else begin
						attrs_d              = attrs_q - 16'd1;
						attr_left_d          = total - HDR_BYTES;
						res_valid            = 1'b1;
						res.kind             = KIND_ATTR_START;
						res.attr_ident       = attr_id_q;
						res.attribute_length = attr_left_d;
						if (attr_left_d != '0)
							phase_d = PH_ADAT;
						else
							do_bnd = 1'b1;
					end
				end
				PH_ADAT: begin
					left_d         = left_dec;
					attr_left_d    = attr_dec;
					res_valid      = 1'b1;
					res.kind       = KIND_ATTR_BYTE;
					res.byte_value = in_byte;
					if (attr_dec == '0)
						do_bnd = 1'b1;
				end
				PH_SKIP: begin
					left_d = left_dec;
					if (left_dec == '0) begin
						phase_d        = PH_VER;
						res_valid      = 1'b1;
						res.kind       = KIND_FRAME_END;
						res.frame_done = 1'b1;
					end
				end
				default: begin
					phase_d = PH_VER;
				end
			endcase

			// skip the rest of a broken frame; the final byte closes it at once
			if (do_fail) begin
				res_valid      = 1'b1;
				res            = '0;
				res.kind       = KIND_ERROR;
				res.error_code = fail_code;
				if (left_d == '0) begin
					phase_d        = PH_VER;
					res.frame_done = 1'b1;
				end else begin
					phase_d = PH_SKIP;
				end
			end

			// after a header or a finished attribute: next attribute, skip, end or missing-attribute error
			if (do_bnd) begin
				if (attrs_d == '0) begin
					if (left_d == '0) begin
						phase_d        = PH_VER;
						res.frame_done = 1'b1;
					end else begin
						phase_d = PH_SKIP;
					end
				end else if (left_d == '0) begin
					phase_d        = PH_VER;
					res            = '0;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_ATTR_MISSING;
					res.frame_done = 1'b1;
				end else begin
					phase_d = PH_ARSV;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_VER;
			len_hi_q    <= '0;
			left_q      <= '0;
			ctrl_q      <= 1'b0;
			mtype_q     <= '0;
			attrs_q     <= '0;
			attr_id_q   <= '0;
			attr_left_q <= '0;
			halted_q    <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			len_hi_q    <= len_hi_d;
			left_q      <= left_d;
			ctrl_q      <= ctrl_d;
			mtype_q     <= mtype_d;
			attrs_q     <= attrs_d;
			attr_id_q   <= attr_id_d;
			attr_left_q <= attr_left_d;
			halted_q    <= halted_d;
		end
	end

endmodule

@@ src/sstp_frame_parser.sv @@
// Top level of the tunnel frame parser: input byte register, parse core, result register.
// Depends on sstp_pkg and sstp_parse_core.
// Byte-serial frame parser for a secure-socket-tunnel stream. One byte is accepted per
// clock; it is parsed while it sits in the input register, and its result (if any) is
// loaded into the output register when the output side is free. Sustained rate is one
// byte per cycle, limited only by out_stall. Bytes that cause no result (headers, skipped
// trailing bytes) are consumed silently. A bad version byte or a frame length under four
// halts parsing until reset; all later bytes are accepted and dropped. expected_version
// (reset 16) may be written via cfg_* while idle.
module sstp_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  byte_value,
	output logic [15:0] msg_type,
	output logic [15:0] attribute_count,
	output logic [7:0]  attr_ident,
	output logic [11:0] attribute_length,
	output logic        frame_done,
	output logic [2:0]  error_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import sstp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	result_t    res_q;
	result_t    res_d;
	logic       res_d_valid;
	logic [7:0] version_q;
	logic       out_free;
	logic       step;

	assign out_free  = !out_valid_q || !out_stall;
	assign step      = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= 8'd16;
		end else if (cfg_valid && cfg_ready) begin
			version_q <= cfg_data;
		end
	end

	// hold the byte while the result side is blocked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= in_byte;
	end

	sstp_parse_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.in_byte          (byte_s1),
		.expected_version (version_q),
		.res_valid        (res_d_valid),
		.res              (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && res_d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_d_valid)
			res_q <= res_d;
	end

	assign out_valid        = out_valid_q;
	assign kind             = res_q.kind;
	assign byte_value       = res_q.byte_value;
	assign msg_type         = res_q.msg_type;
	assign attribute_count  = res_q.attribute_count;
	assign attr_ident       = res_q.attr_ident;
	assign attribute_length = res_q.attribute_length;
	assign frame_done       = res_q.frame_done;
	assign error_code       = res_q.error_code;

`ifndef SYNTHESIS
	a_err_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |-> error_code != ERR_NONE)
		else $error("error request without error code");

	a_code_only_on_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_ERROR |-> error_code == ERR_NONE)
		else $error("error code on non-error request");

	a_end_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_FRAME_END |-> frame_done)
		else $error("frame end request without frame_done");

	a_halt_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR
		&& (error_code == ERR_VERSION || error_code == ERR_FRAME_LEN) |-> !frame_done)
		else $error("halting error marked as frame end");
`endif

endmodule

@@ dv/tb_sstp_frame_parser.sv @@
// Self-checking testbench for sstp_frame_parser: directed frames, then a random tunnel stream.
// Depends on sstp_pkg and the parser RTL; a byte-level predictor supplies the expected items.
`timescale 1ns / 100ps

module tb_sstp_frame_parser;
	import sstp_pkg::*;

	localparam int WATCHDOG_CYCLES = 1000;
	localparam int SETTLE_CYCLES   = 6;
	localparam int RANDOM_BYTES    = 1100;

	typedef enum int {
		CF_GOOD,
		CF_MISSING,
		CF_BADLEN,
		CF_OVERRUN,
		CF_SHORT,
		CF_NOISE
	} ctrl_fault_e;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  byte_value;
	logic [15:0] msg_type;
	logic [15:0] attribute_count;
	logic [7:0]  attr_ident;
	logic [11:0] attribute_length;
	logic        frame_done;
	logic [2:0]  error_code;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'h00;

	sstp_frame_parser dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.in_byte          (in_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.kind             (kind),
		.byte_value       (byte_value),
		.msg_type         (msg_type),
		.attribute_count  (attribute_count),
		.attr_ident       (attr_ident),
		.attribute_length (attribute_length),
		.frame_done       (frame_done),
		.error_code       (error_code),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Parser state mirror
	logic [3:0]  st_phase      = PH_VER;
	logic [7:0]  st_len_hi     = 8'h00;
	logic [11:0] st_frame_left = 12'h000;
	logic        st_ctrl       = 1'b0;
	logic [15:0] st_mtype      = 16'h0000;
	logic [15:0] st_attr_left  = 16'h0000;
	logic [7:0]  st_attr_id    = 8'h00;
	logic [11:0] st_attr_bytes = 12'h000;
	logic        st_halted     = 1'b0;
	logic [7:0]  st_version    = 8'h10;

	result_t     items_due[$];
	logic [7:0]  tx_q[$];
	logic [7:0]  cur_version = 8'h10;
	bit          in_pace = 1'b1;
	bit          out_pace = 1'b1;
	int          stall_left = 0;
	int          errors = 0;
	int          bytes_sent = 0;
	int          frames_sent = 0;
	int          items_checked = 0;
	int          versions_used = 1;

	function automatic result_t item_of(input logic [2:0] k, input logic done,
			input logic [2:0] err);
		result_t r;
		r = '0;
		r.kind = k;
		r.frame_done = done;
		r.error_code = err;
		return r;
	endfunction

	// Flag the frame; skip the rest of it unless this was its final byte
	function automatic result_t frame_fault(input logic [2:0] err);
		if (st_frame_left == 12'h000) begin
			st_phase = PH_VER;
			return item_of(KIND_ERROR, 1'b1, err);
		end
		st_phase = PH_SKIP;
		return item_of(KIND_ERROR, 1'b0, err);
	endfunction

	// Decide what follows a control header or a finished attribute
	function automatic result_t attr_boundary(input result_t r);
		result_t o;
		o = r;
		if (st_attr_left == 16'h0000) begin
			if (st_frame_left == 12'h000) begin
				st_phase = PH_VER;
				o.frame_done = 1'b1;
			end else begin
				st_phase = PH_SKIP;
			end
			return o;
		end
		if (st_frame_left == 12'h000) begin
			st_phase = PH_VER;
			return item_of(KIND_ERROR, 1'b1, ERR_ATTR_MISSING);
		end
		st_phase = PH_ARSV;
		return o;
	endfunction

	function automatic bit parse_byte(input logic [7:0] b, output result_t r);
		logic [11:0] total;
		r = '0;
		if (st_halted)
			return 1'b0;
		case (st_phase)
			PH_VER: begin
				if (b != st_version) begin
					st_halted = 1'b1;
					r = item_of(KIND_ERROR, 1'b0, ERR_VERSION);
					return 1'b1;
				end
				st_ctrl = 1'b0;
				st_phase = PH_FLAG;
				return 1'b0;
			end
			PH_FLAG: begin
				st_ctrl = b[0];
				st_phase = PH_LHI;
				return 1'b0;
			end
			PH_LHI: begin
				st_len_hi = b;
				st_phase = PH_LLO;
				return 1'b0;
			end
			PH_LLO: begin
				total = {st_len_hi[3:0], b};
				if (total < HDR_BYTES) begin
					st_halted = 1'b1;
					st_phase = PH_VER;
					r = item_of(KIND_ERROR, 1'b0, ERR_FRAME_LEN);
					return 1'b1;
				end
				st_frame_left = total - HDR_BYTES;
				if (!st_ctrl) begin
					if (st_frame_left == 12'h000) begin
						st_phase = PH_VER;
						r = item_of(KIND_FRAME_END, 1'b1, ERR_NONE);
						return 1'b1;
					end
					st_phase = PH_DATA;
					return 1'b0;
				end
				if (st_frame_left < 12'd4) begin
					r = frame_fault(ERR_CTRL_BODY);
					return 1'b1;
				end
				st_phase = PH_MTH;
				return 1'b0;
			end
			PH_DATA: begin
				st_frame_left = st_frame_left - 12'd1;
				r = item_of(KIND_DATA, 1'b0, ERR_NONE);
				r.byte_value = b;
				if (st_frame_left == 12'h000) begin
					st_phase = PH_VER;
					r.frame_done = 1'b1;
				end
				return 1'b1;
			end
			PH_MTH: begin
				st_mtype = {b, 8'h00};
				st_frame_left = st_frame_left - 12'd1;
				st_phase = PH_MTL;
				return 1'b0;
			end
			PH_MTL: begin
				st_mtype[7:0] = b;
				st_frame_left = st_frame_left - 12'd1;
				st_phase = PH_CNH;
				return 1'b0;
			end
			PH_CNH: begin
				st_attr_left = {b, 8'h00};
				st_frame_left = st_frame_left - 12'd1;
				st_phase = PH_CNL;
				return 1'b0;
			end
			PH_CNL: begin
				st_attr_left[7:0] = b;
				st_frame_left = st_frame_left - 12'd1;
				r = item_of(KIND_CTRL_HDR, 1'b0, ERR_NONE);
				r.msg_type = st_mtype;
				r.attribute_count = st_attr_left;
				r = attr_boundary(r);
				return 1'b1;
			end
			PH_ARSV, PH_AID, PH_ALH: begin
				if (st_phase == PH_AID)
					st_attr_id = b;
				if (st_phase == PH_ALH)
					st_len_hi = b;
				st_frame_left = st_frame_left - 12'd1;
				if (st_frame_left == 12'h000) begin
					r = frame_fault(ERR_ATTR_OVERRUN);
					return 1'b1;
				end
				st_phase = st_phase + 4'd1;
				return 1'b0;
			end
			PH_ALL: begin
				total = {st_len_hi[3:0], b};
				st_frame_left = st_frame_left - 12'd1;
				if (total < HDR_BYTES) begin
					r = frame_fault(ERR_ATTR_LEN);
					return 1'b1;
				end
				if (total - HDR_BYTES > st_frame_left) begin
					r = frame_fault(ERR_ATTR_OVERRUN);
					return 1'b1;
				end
				st_attr_left = st_attr_left - 16'd1;
				st_attr_bytes = total - HDR_BYTES;
				r = item_of(KIND_ATTR_START, 1'b0, ERR_NONE);
				r.attr_ident = st_attr_id;
				r.attribute_length = st_attr_bytes;
				if (st_attr_bytes != 12'h000) begin
					st_phase = PH_ADAT;
					return 1'b1;
				end
				r = attr_boundary(r);
				return 1'b1;
			end
			PH_ADAT: begin
				st_frame_left = st_frame_left - 12'd1;
				st_attr_bytes = st_attr_bytes - 12'd1;
				r = item_of(KIND_ATTR_BYTE, 1'b0, ERR_NONE);
				r.byte_value = b;
				if (st_attr_bytes != 12'h000)
					return 1'b1;
				r = attr_boundary(r);
				return 1'b1;
			end
			PH_SKIP: begin
				st_frame_left = st_frame_left - 12'd1;
				if (st_frame_left == 12'h000) begin
					st_phase = PH_VER;
					r = item_of(KIND_FRAME_END, 1'b1, ERR_NONE);
					return 1'b1;
				end
				return 1'b0;
			end
			default: begin
				st_phase = PH_VER;
				return 1'b0;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
	endtask

	// Result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (items_due.size() == 0) begin
				report_mismatch($sformatf("result with none pending, kind %0d", kind));
			end else begin
				want = items_due.pop_front();
				items_checked++;
				check_field("kind", 16'(kind), 16'(want.kind));
				check_field("byte_value", 16'(byte_value), 16'(want.byte_value));
				check_field("msg_type", msg_type, want.msg_type);
				check_field("attribute_count", attribute_count, want.attribute_count);
				check_field("attr_ident", 16'(attr_ident), 16'(want.attr_ident));
				check_field("attribute_length", 16'(attribute_length),
					16'(want.attribute_length));
				check_field("frame_done", 16'(frame_done), 16'(want.frame_done));
				check_field("error_code", 16'(error_code), 16'(want.error_code));
			end
		end
	end

	// Receiver back-pressure: draw a new hold-off per accepted result
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			stall_left = out_pace ? $urandom_range(0, 10) : 0;
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no handshake for %0d cycles", WATCHDOG_CYCLES);
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		result_t r;
		gap = in_pace ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (in_stall);
		if (parse_byte(b, r))
			items_due.push_back(r);
		bytes_sent++;
	endtask

	task automatic flush_tx();
		while (tx_q.size() > 0)
			send_byte(tx_q.pop_front());
	endtask

	// Hold the input, drain results, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (items_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_version(input logic [7:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		st_version = v;
		cur_version = v;
		versions_used++;
	endtask

	// Upper nibble of the length high byte is outside the 12-bit length
	task automatic add_header(input logic ctrl, input int total);
		logic [11:0] len12;
		logic [7:0] flag;
		len12 = total[11:0];
		flag = 8'($urandom_range(0, 255));
		flag[0] = ctrl;
		tx_q.push_back(cur_version);
		tx_q.push_back(flag);
		tx_q.push_back({4'($urandom_range(0, 15)), len12[11:8]});
		tx_q.push_back(len12[7:0]);
		frames_sent++;
	endtask

	task automatic add_data_frame(input int n);
		add_header(1'b0, n + 4);
		repeat (n) tx_q.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic add_control_frame(input ctrl_fault_e fault, input int n_attr,
			input int trail);
		logic [7:0]  body[$];
		logic [15:0] mtype;
		logic [15:0] count;
		logic [11:0] alen;
		int n_data;
		int bad;
		mtype = 16'($urandom_range(0, 65535));
		count = 16'(n_attr);
		bad = $urandom_range(0, (n_attr > 0) ? n_attr - 1 : 0);
		if (fault == CF_MISSING)
			count = count + 16'($urandom_range(1, 3));
		if (fault == CF_NOISE)
			count = 16'($urandom_range(0, 65535));
		if (fault == CF_SHORT) begin
			repeat ($urandom_range(0, 3)) body.push_back(8'($urandom_range(0, 255)));
		end else begin
			body.push_back(mtype[15:8]);
			body.push_back(mtype[7:0]);
			body.push_back(count[15:8]);
			body.push_back(count[7:0]);
			for (int i = 0; i < n_attr; i++) begin
				n_data = $urandom_range(0, 6);
				alen = 12'(n_data + 4);
				if (fault == CF_BADLEN && i == bad)
					alen = 12'($urandom_range(0, 3));
				if (fault == CF_OVERRUN && i == bad)
					alen = alen + 12'($urandom_range(200, 1000));
				body.push_back(8'($urandom_range(0, 255)));
				body.push_back(8'($urandom_range(0, 255)));
				body.push_back({4'($urandom_range(0, 15)), alen[11:8]});
				body.push_back(alen[7:0]);
				repeat (n_data) body.push_back(8'($urandom_range(0, 255)));
			end
			repeat (trail) body.push_back(8'($urandom_range(0, 255)));
		end
		add_header(1'b1, body.size() + 4);
		foreach (body[i]) tx_q.push_back(body[i]);
	endtask

	task automatic add_random_frame();
		int pick;
		int trail;
		pick = $urandom_range(0, 99);
		trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		if (pick < 35) begin
			if ($urandom_range(0, 19) == 0)
				add_data_frame($urandom_range(25, 300));
			else
				add_data_frame($urandom_range(0, 24));
		end else if (pick < 70) begin
			add_control_frame(CF_GOOD, $urandom_range(0, 3), trail);
		end else begin
			case ($urandom_range(0, 4))
				0: add_control_frame(CF_MISSING, $urandom_range(0, 3), trail);
				1: add_control_frame(CF_BADLEN, $urandom_range(1, 3), trail);
				2: add_control_frame(CF_OVERRUN, $urandom_range(1, 3), trail);
				3: add_control_frame(CF_SHORT, 0, 0);
				default: add_control_frame(CF_NOISE, $urandom_range(0, 3), trail);
			endcase
		end
	endtask

	task automatic test_data_frames();
		add_header(1'b0, 4);
		add_header(1'b0, 8);
		tx_q.push_back(8'h00);
		tx_q.push_back(8'hFF);
		tx_q.push_back(8'h55);
		tx_q.push_back(8'hAA);
		flush_tx();
	endtask

	task automatic test_control_frames();
		add_control_frame(CF_GOOD, 0, 0);
		// one attribute with no data, extreme type and masked length nibble
		add_header(1'b1, 12);
		tx_q.push_back(8'hFF);
		tx_q.push_back(8'hFF);
		tx_q.push_back(8'h00);
		tx_q.push_back(8'h01);
		tx_q.push_back(8'hFF);
		tx_q.push_back(8'hFF);
		tx_q.push_back(8'hF0);
		tx_q.push_back(8'h04);
		add_control_frame(CF_GOOD, 2, 2);
		flush_tx();
	endtask

	task automatic test_control_errors();
		add_control_frame(CF_SHORT, 0, 0);
		add_control_frame(CF_BADLEN, 1, 1);
		add_control_frame(CF_OVERRUN, 1, 0);
		add_control_frame(CF_MISSING, 1, 0);
		// frame ends inside an attribute header
		add_header(1'b1, 10);
		tx_q.push_back(8'h12);
		tx_q.push_back(8'h34);
		tx_q.push_back(8'h00);
		tx_q.push_back(8'h01);
		tx_q.push_back(8'h00);
		tx_q.push_back(8'h07);
		flush_tx();
	endtask

	task automatic test_version_setting();
		logic [7:0] versions[4];
		versions = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), 8'h10};
		in_pace = 1'b0;
		out_pace = 1'b0;
		foreach (versions[i]) begin
			write_version(versions[i]);
			add_data_frame(2);
			add_control_frame(CF_GOOD, 1, 0);
			flush_tx();
		end
	endtask

	task automatic test_random_stream();
		int batch_end;
		for (int k = 0; k < 4; k++) begin
			write_version((k == 3) ? 8'hFF : 8'($urandom_range(0, 255)));
			in_pace = (k != 1);
			out_pace = (k != 2);
			batch_end = bytes_sent + RANDOM_BYTES / 4;
			while (bytes_sent < batch_end) begin
				add_random_frame();
				flush_tx();
			end
		end
	endtask

	// Long data frame sent back to back against receiver back-pressure
	task automatic test_long_frame();
		in_pace = 1'b0;
		out_pace = 1'b1;
		add_data_frame(300);
		flush_tx();
	endtask

	// Either halting error; every later byte must be dropped
	task automatic test_halt();
		settle();
		in_pace = 1'b1;
		if ($urandom_range(0, 1) == 0) begin
			tx_q.push_back(cur_version ^ 8'($urandom_range(1, 255)));
		end else begin
			tx_q.push_back(cur_version);
			tx_q.push_back(8'($urandom_range(0, 255)));
			tx_q.push_back({4'($urandom_range(0, 15)), 4'h0});
			tx_q.push_back(8'($urandom_range(0, 3)));
		end
		repeat (8) tx_q.push_back(8'($urandom_range(0, 255)));
		flush_tx();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_data_frames();
		test_control_frames();
		test_control_errors();
		test_version_setting();
		test_random_stream();
		test_long_frame();
		test_halt();
		settle();
		repeat (10) @(posedge clk);
		$display("Sent %0d bytes in %0d frames under %0d version settings;",
			bytes_sent, frames_sent, versions_used);
		$display("checked %0d result items, stream ended in the halted state.", items_checked);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
